[design/asc_pkg.sv]
// ----------------------------------------------------------------------------
// asc_pkg: shared types and constants for the accelerometer step counter
// Holds the transaction payload types, the configuration register map, the
// state encodings and the fixed constants of the step detection.
// ----------------------------------------------------------------------------
package asc_pkg;

    localparam int SAMPLE_W = 12;
    localparam int TH_W     = SAMPLE_W + 1;
    localparam int SENS_W   = 12;
    localparam int IVL_W    = 16;
    localparam int TOTAL_W  = 32;
    localparam int PEND_W   = 8;
    localparam int IVLCFG_W = 10;
    localparam int STEPS_W  = 8;
    localparam int SWING_W  = 12;

    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    localparam logic [SAMPLE_W-1:0]        SWING_CAP  = 12'd2000;
    localparam logic [SENS_W-1:0]          SENS_CAP   = 12'd1800;
    localparam logic [SENS_W-1:0]          SENS_BAD   = 12'd100;
    localparam logic [SENS_W-1:0]          SENS_RST   = 12'd4095;
    localparam logic signed [SAMPLE_W-1:0] XMID_MIN   = 12'sd950;
    localparam logic [STEPS_W-1:0]         INV_MAX    = 8'd255;
    localparam logic [IVL_W-1:0]           IVL_MAX    = 16'hFFFF;

    localparam logic [IVLCFG_W-1:0] RST_MIN_INTERVAL     = 10'd10;
    localparam logic [IVLCFG_W-1:0] RST_MAX_INTERVAL     = 10'd100;
    localparam logic [STEPS_W-1:0]  RST_REGULARITY_STEPS = 8'd4;
    localparam logic [STEPS_W-1:0]  RST_INVALID_LIMIT    = 8'd4;
    localparam logic [SWING_W-1:0]  RST_MIN_SWING        = 12'd50;

    typedef enum logic [2:0] {
        REG_MIN_INTERVAL     = 3'd0,
        REG_MAX_INTERVAL     = 3'd1,
        REG_REGULARITY_STEPS = 3'd2,
        REG_INVALID_LIMIT    = 3'd3,
        REG_MIN_SWING        = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        FR_IDLE        = 3'd0,
        FR_NOT_REGULAR = 3'd1,
        FR_OK          = 3'd2,
        FR_TOO_SMALL   = 3'd3,
        FR_TOO_LARGE   = 3'd4
    } t_find;

    typedef enum logic [1:0] {
        LV_IDLE = 2'd0,
        LV_HIGH = 2'd1,
        LV_LOW  = 2'd2
    } t_level;

    typedef enum logic [1:0] {
        RM_REGULAR = 2'd0,
        RM_SEEK    = 2'd1,
        RM_FRESH   = 2'd2
    } t_rmode;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
    } t_in_item;

    typedef struct packed {
        logic [TOTAL_W-1:0] step_total;
        t_find              find_result;
    } t_out_item;

    typedef struct packed {
        logic [IVLCFG_W-1:0] min_interval;
        logic [IVLCFG_W-1:0] max_interval;
        logic [STEPS_W-1:0]  regularity_steps;
        logic [STEPS_W-1:0]  invalid_limit;
        logic [SWING_W-1:0]  min_swing;
    } t_cfg;

    // Detection inputs of one sample as seen by the step detector.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] ad;
        logic signed [TH_W-1:0]     high;
        logic signed [TH_W-1:0]     low;
        logic [SENS_W-1:0]          sens;
        logic                       bad;
    } t_lvl_in;

endpackage

[design/asc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// asc_cfg_regs: configuration register file
// APB-style write and read access to the five step detection settings.
// ----------------------------------------------------------------------------
module asc_cfg_regs
    import asc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_interval     <= RST_MIN_INTERVAL;
            r_cfg.max_interval     <= RST_MAX_INTERVAL;
            r_cfg.regularity_steps <= RST_REGULARITY_STEPS;
            r_cfg.invalid_limit    <= RST_INVALID_LIMIT;
            r_cfg.min_swing        <= RST_MIN_SWING;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_MIN_INTERVAL:     r_cfg.min_interval     <= pwdata[IVLCFG_W-1:0];
                REG_MAX_INTERVAL:     r_cfg.max_interval     <= pwdata[IVLCFG_W-1:0];
                REG_REGULARITY_STEPS: r_cfg.regularity_steps <= pwdata[STEPS_W-1:0];
                REG_INVALID_LIMIT:    r_cfg.invalid_limit    <= pwdata[STEPS_W-1:0];
                REG_MIN_SWING:        r_cfg.min_swing        <= pwdata[SWING_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_MIN_INTERVAL:     prdata = DATA_W'(r_cfg.min_interval);
            REG_MAX_INTERVAL:     prdata = DATA_W'(r_cfg.max_interval);
            REG_REGULARITY_STEPS: prdata = DATA_W'(r_cfg.regularity_steps);
            REG_INVALID_LIMIT:    prdata = DATA_W'(r_cfg.invalid_limit);
            REG_MIN_SWING:        prdata = DATA_W'(r_cfg.min_swing);
            default:              prdata = '0;
        endcase
    end

endmodule

[design/asc_block_stats.sv]
// ----------------------------------------------------------------------------
// asc_block_stats: per-block extremes and dynamic thresholds
// Tracks the x and y extremes over each block of samples and, at the end of
// a block, derives the y thresholds, the sensitivity and the bad-block flag.
// Also holds the y sample of the transaction in the first pipeline stage.
// ----------------------------------------------------------------------------
module asc_block_stats
    import asc_pkg::*;
#(
    parameter int BLOCK_LEN = 50
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output t_lvl_in  o_lvl
);

    localparam int CNT_W = $clog2(BLOCK_LEN + 1);

    logic [CNT_W-1:0]           r_cnt;
    logic signed [SAMPLE_W-1:0] r_max_x, r_min_x, r_max_y, r_min_y;
    logic signed [TH_W-1:0]     r_high, r_low;
    logic [SENS_W-1:0]          r_sens;
    logic                       r_bad, r_live;
    logic signed [SAMPLE_W-1:0] r_y;

    logic signed [SAMPLE_W-1:0] x, y;
    logic signed [SAMPLE_W-1:0] n_max_x, n_min_x, n_max_y, n_min_y;
    logic                       block_end;
    logic [SAMPLE_W-1:0]        swing, swing_x;
    logic signed [SAMPLE_W-1:0] mid_x;
    logic signed [TH_W-1:0]     min_e, max_e, mid, hi_span, lo_span, n_high, n_low;
    logic [SAMPLE_W+3:0]        swing12;
    logic [SENS_W-1:0]          n_sens;
    logic                       n_bad;

    always_comb begin
        x = i_item.accel_x;
        y = i_item.accel_y;
        n_max_x = (x > r_max_x) ? x : r_max_x;
        n_min_x = (x < r_min_x) ? x : r_min_x;
        n_max_y = (y > r_max_y) ? y : r_max_y;
        n_min_y = (y < r_min_y) ? y : r_min_y;

        block_end = (r_cnt == CNT_W'(BLOCK_LEN - 1));

        // Max is never below min once a sample is in, so the swing is unsigned.
        swing   = SAMPLE_W'(n_max_y - n_min_y);
        swing_x = SAMPLE_W'(n_max_x - n_min_x);
        mid_x   = n_min_x + $signed({1'b0, swing_x[SAMPLE_W-1:1]});

        min_e   = {n_min_y[SAMPLE_W-1], n_min_y};
        max_e   = {n_max_y[SAMPLE_W-1], n_max_y};
        mid     = min_e + $signed({2'b00, swing[SAMPLE_W-1:1]});
        hi_span = max_e - mid;
        lo_span = mid - min_e;
        n_high  = mid + (hi_span >>> 1);
        n_low   = mid - (lo_span >>> 1);

        // Three quarters of the swing as swing*12/16.
        swing12 = ({4'b0000, swing} << 3) + ({4'b0000, swing} << 2);

        n_bad = 1'b0;
        if (swing >= SWING_CAP) begin
            n_sens = SENS_CAP;
        end else if (swing >= i_cfg.min_swing) begin
            n_sens = swing12[SAMPLE_W+3:4];
        end else begin
            n_sens = SENS_BAD;
            n_bad  = 1'b1;
        end
        if (mid_x < XMID_MIN) begin
            n_bad = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_max_x <= SAMPLE_MIN;
            r_min_x <= SAMPLE_MAX;
            r_max_y <= SAMPLE_MIN;
            r_min_y <= SAMPLE_MAX;
            r_high  <= '0;
            r_low   <= '0;
            r_sens  <= SENS_RST;
            r_bad   <= 1'b0;
            r_live  <= 1'b0;
        end else if (i_accept) begin
            if (block_end) begin
                r_cnt   <= '0;
                r_max_x <= SAMPLE_MIN;
                r_min_x <= SAMPLE_MAX;
                r_max_y <= SAMPLE_MIN;
                r_min_y <= SAMPLE_MAX;
                r_high  <= n_high;
                r_low   <= n_low;
                r_sens  <= n_sens;
                r_bad   <= n_bad;
                r_live  <= 1'b1;
            end else begin
                r_cnt   <= r_cnt + 1'b1;
                r_max_x <= n_max_x;
                r_min_x <= n_min_x;
                r_max_y <= n_max_y;
                r_min_y <= n_min_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_y <= y;
        end
    end

    // While a sample sits in this stage the block state reflects that sample.
    assign o_lvl.ad   = r_live ? r_y : '0;
    assign o_lvl.high = r_high;
    assign o_lvl.low  = r_low;
    assign o_lvl.sens = r_sens;
    assign o_lvl.bad  = r_bad;

endmodule

[design/asc_step_detect.sv]
// ----------------------------------------------------------------------------
// asc_step_detect: level tracking and time-window regularity
// Follows the y extremes with a high/low machine, raises step candidates and
// counts steps once the step rhythm has proven regular.
// ----------------------------------------------------------------------------
module asc_step_detect
    import asc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_lvl_in   i_lvl,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic [IVL_W-1:0]           r_ivl, n_ivl, ivl_inc;
    t_level                     r_lvl, n_lvl;
    logic signed [SAMPLE_W-1:0] r_old, n_old, r_new, n_new;
    t_rmode                     r_mode, n_mode;
    logic [PEND_W-1:0]          r_pend, n_pend, pend_inc;
    logic [STEPS_W-1:0]         r_inv, n_inv, inv_sat;
    logic [TOTAL_W-1:0]         r_total, n_total;

    logic signed [TH_W-1:0]     ad_e;
    logic signed [TH_W:0]       diff, diff_neg, sens_e;
    logic [IVL_W-1:0]           min_e, max_e;
    logic                       cand, restart;
    t_find                      res;

    always_comb begin
        n_lvl   = r_lvl;
        n_old   = r_old;
        n_new   = r_new;
        n_mode  = r_mode;
        n_pend  = r_pend;
        n_inv   = r_inv;
        n_total = r_total;
        res     = FR_IDLE;
        restart = 1'b0;

        ivl_inc  = (r_ivl != IVL_MAX) ? r_ivl + 1'b1 : r_ivl;
        n_ivl    = ivl_inc;
        min_e    = IVL_W'(i_cfg.min_interval);
        max_e    = IVL_W'(i_cfg.max_interval);
        pend_inc = r_pend + 1'b1;
        inv_sat  = (r_inv < INV_MAX) ? r_inv + 1'b1 : r_inv;

        ad_e = {i_lvl.ad[SAMPLE_W-1], i_lvl.ad};
        if (ad_e > i_lvl.high) begin
            if (r_lvl != LV_HIGH) begin
                n_old = r_new;
            end
            n_lvl = LV_HIGH;
            if (i_lvl.ad > r_new) begin
                n_new = i_lvl.ad;
            end
        end else if (ad_e < i_lvl.low) begin
            if (r_lvl != LV_LOW) begin
                n_old = r_new;
            end
            n_lvl = LV_LOW;
            if (i_lvl.ad < r_new) begin
                n_new = i_lvl.ad;
            end
        end

        diff     = {{2{n_old[SAMPLE_W-1]}}, n_old} - {{2{n_new[SAMPLE_W-1]}}, n_new};
        diff_neg = -diff;
        sens_e   = $signed({2'b00, i_lvl.sens});
        cand     = ((diff > sens_e) || (diff_neg > sens_e)) && (ivl_inc > min_e);
        if (cand) begin
            n_old = n_new;
        end

        if (cand && !i_lvl.bad) begin
            if (r_mode == RM_FRESH) begin
                n_pend = pend_inc;
                n_ivl  = '0;
                n_mode = RM_SEEK;
                n_inv  = '0;
                res    = FR_NOT_REGULAR;
            end else if (ivl_inc >= min_e && ivl_inc <= max_e) begin
                n_inv = '0;
                case (r_mode)
                    RM_SEEK: begin
                        n_pend = pend_inc;
                        n_ivl  = '0;
                        if (pend_inc >= i_cfg.regularity_steps) begin
                            n_mode  = RM_REGULAR;
                            n_total = r_total + TOTAL_W'(pend_inc);
                            n_pend  = '0;
                            res     = FR_OK;
                        end else begin
                            res = FR_NOT_REGULAR;
                        end
                    end
                    RM_REGULAR: begin
                        n_total = r_total + 1'b1;
                        n_pend  = '0;
                        n_ivl   = '0;
                        res     = FR_OK;
                    end
                    default: ;
                endcase
            end else if (ivl_inc < min_e) begin
                // Too close: a regular rhythm tolerates a few before it is lost.
                case (r_mode)
                    RM_REGULAR: begin
                        if (inv_sat >= i_cfg.invalid_limit) begin
                            restart = 1'b1;
                        end else begin
                            n_inv = inv_sat;
                            n_ivl = '0;
                        end
                    end
                    RM_SEEK: restart = 1'b1;
                    default: ;
                endcase
                res = FR_TOO_SMALL;
            end else begin
                restart = 1'b1;
                res     = FR_TOO_LARGE;
            end
        end else if (ivl_inc >= max_e) begin
            restart = 1'b1;
        end

        if (restart) begin
            n_inv  = '0;
            n_mode = RM_SEEK;
            n_pend = '0;
            n_ivl  = '0;
        end

        o_result.step_total  = n_total;
        o_result.find_result = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ivl   <= '0;
            r_lvl   <= LV_IDLE;
            r_old   <= '0;
            r_new   <= '0;
            r_mode  <= RM_FRESH;
            r_pend  <= '0;
            r_inv   <= '0;
            r_total <= '0;
        end else if (i_fire) begin
            r_ivl   <= n_ivl;
            r_lvl   <= n_lvl;
            r_old   <= n_old;
            r_new   <= n_new;
            r_mode  <= n_mode;
            r_pend  <= n_pend;
            r_inv   <= n_inv;
            r_total <= n_total;
        end
    end

endmodule

[design/accel_step_counter.sv]
// A result transaction is registered in the sample stage and then in the result register.
// Throughput: one sample per cycle unless the receiver stalls; the sample stage and
// the result register each hold one transaction and advance independently under downstream stall.
// Block statistics update in the sample stage, step detection in the result stage.
// Reset (synchronous, active low) clears the valids, block and detection state and restores register defaults.
// ----------------------------------------------------------------------------
// accel_step_counter: pedometer with dynamic thresholds
// Counts steps from x/y accelerometer samples, one result per sample.
// ----------------------------------------------------------------------------
module accel_step_counter
    import asc_pkg::*;
#(
    parameter int BLOCK_LEN = 50
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in_item          i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out_item         o_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg      cfg;
    t_lvl_in   lvl;
    t_out_item result;

    logic      r_s1_valid, r_out_valid;
    t_out_item r_out;
    logic      out_ready, s1_ready, in_accept, s1_fire;

    assign out_ready = !r_out_valid || !i_stall;
    assign s1_ready  = !r_s1_valid || out_ready;
    assign in_accept = i_valid && s1_ready;
    assign s1_fire   = r_s1_valid && out_ready;

    assign o_stall = !s1_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    asc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    asc_block_stats #(
        .BLOCK_LEN (BLOCK_LEN)
    ) u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_data),
        .i_cfg    (cfg),
        .o_lvl    (lvl)
    );

    asc_step_detect u_detect (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (s1_fire),
        .i_lvl    (lvl),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= result;
        end
    end

endmodule

[design/asc_checker.sv]
// ----------------------------------------------------------------------------
// asc_checker: port-level checks for the step counter
// Watches the handshakes of the top level and checks pipeline behavior.
// ----------------------------------------------------------------------------
module asc_checker
    import asc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_data
);

    // A result that is held back must stay put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("result changed or dropped while stalled");

    // The input is only held off when the result register is full and stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled result");

    // An accepted transaction produces a valid result once it leaves the sample stage without a receiver stall.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall |=> o_valid)
        else $error("accepted transaction did not produce a result");

    // No result leaves the block in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind accel_step_counter asc_checker u_asc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the accelerometer step counter
// Streams x/y samples through the block under five register settings. Each
// sample is run through a behavioral model of the dynamic-threshold step
// detector, and every result transaction is checked against it field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import asc_pkg::*;

    localparam int BLOCK_SAMPLES  = 50;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SHOWN_MAX      = 10;
    localparam int NUM_PHASES     = 5;
    localparam int PHASE_ITEMS [NUM_PHASES] = '{220, 200, 120, 200, 210};
    localparam int EDGE_X [12] = '{-2048, 2047, 0, -1, 2047, -2048, 1365, -1366,
                                   950, 949, 1, -2048};
    localparam int EDGE_Y [12] = '{2047, -2048, 0, -1, 2047, -2048, -1366, 1365,
                                   0, 1, -2048, 1};

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    t_in_item          i_data  = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    t_out_item         o_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic rx_hold     = 1'b0;

    t_in_item  sample_feed[$];
    t_out_item expected_results[$];
    int        n_queued = 0;
    int        n_in     = 0;
    int        n_out    = 0;
    int        n_fail   = 0;
    int        n_shown  = 0;
    int        stuck_cycles = 0;
    int        kind_seen [5] = '{0, 0, 0, 0, 0};

    // Mirror of the detector state, starting from its reset values.
    t_cfg                cfg = '{RST_MIN_INTERVAL, RST_MAX_INTERVAL, RST_REGULARITY_STEPS,
                                 RST_INVALID_LIMIT, RST_MIN_SWING};
    int unsigned         gap_cnt = 0;
    int unsigned         blk_cnt = 0;
    int                  x_hi    = int'(SAMPLE_MIN);
    int                  x_lo    = int'(SAMPLE_MAX);
    int                  y_hi    = int'(SAMPLE_MIN);
    int                  y_lo    = int'(SAMPLE_MAX);
    int                  thr_hi  = 0;
    int                  thr_lo  = 0;
    int                  sens    = int'(SENS_RST);
    int                  ext_old = 0;
    int                  ext_new = 0;
    bit                  blk_bad = 1'b0;
    bit                  y_live  = 1'b0;
    t_level              lvl     = LV_IDLE;
    t_rmode              rmode   = RM_FRESH;
    logic [PEND_W-1:0]   pend    = '0;
    logic [STEPS_W-1:0]  n_close = '0;
    logic [TOTAL_W-1:0]  steps   = '0;

    accel_step_counter #(.BLOCK_LEN(BLOCK_SAMPLES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic void restart_seek();
        n_close = '0;
        rmode   = RM_SEEK;
        pend    = '0;
        gap_cnt = 0;
    endfunction

    // Regularity machine: steps are only credited after enough in-window steps.
    function automatic t_find window_step();
        t_find res;
        res = FR_IDLE;
        if (rmode == RM_FRESH) begin
            pend    = pend + 1'b1;
            gap_cnt = 0;
            rmode   = RM_SEEK;
            n_close = '0;
            return FR_NOT_REGULAR;
        end
        if (gap_cnt >= cfg.min_interval && gap_cnt <= cfg.max_interval) begin
            n_close = '0;
            if (rmode == RM_SEEK) begin
                pend = pend + 1'b1;
                if (pend >= cfg.regularity_steps) begin
                    rmode = RM_REGULAR;
                    steps = steps + pend;
                    pend  = '0;
                    res   = FR_OK;
                end else begin
                    res = FR_NOT_REGULAR;
                end
                gap_cnt = 0;
            end else if (rmode == RM_REGULAR) begin
                steps   = steps + 1'b1;
                pend    = '0;
                gap_cnt = 0;
                res     = FR_OK;
            end
        end else if (gap_cnt < cfg.min_interval) begin
            if (rmode == RM_REGULAR) begin
                if (n_close < INV_MAX) n_close = n_close + 1'b1;
                if (n_close >= cfg.invalid_limit) restart_seek();
                else gap_cnt = 0;
            end else if (rmode == RM_SEEK) begin
                restart_seek();
            end
            res = FR_TOO_SMALL;
        end else begin
            restart_seek();
            res = FR_TOO_LARGE;
        end
        return res;
    endfunction

    function automatic t_out_item predict_sample(t_in_item s);
        int        sx, sy, swing, mid, mid_x, ad, diff;
        bit        cand;
        t_find     res;
        t_out_item o;
        sx   = int'(s.accel_x);
        sy   = int'(s.accel_y);
        cand = 1'b0;
        res  = FR_IDLE;
        if (gap_cnt < IVL_MAX) gap_cnt++;
        if (sx > x_hi) x_hi = sx;
        if (sx < x_lo) x_lo = sx;
        if (sy > y_hi) y_hi = sy;
        if (sy < y_lo) y_lo = sy;

        blk_cnt = (blk_cnt + 1) & 32'h3F;
        if (blk_cnt == BLOCK_SAMPLES) begin
            swing   = y_hi - y_lo;
            mid     = y_lo + swing / 2;
            mid_x   = x_lo + (x_hi - x_lo) / 2;
            blk_cnt = 0;
            thr_hi  = mid + (y_hi - mid) / 2;
            thr_lo  = mid - (mid - y_lo) / 2;
            blk_bad = 1'b0;
            if (swing >= int'(SWING_CAP)) begin
                sens = int'(SENS_CAP);
            end else if (swing >= int'(cfg.min_swing)) begin
                // Three quarters of the swing.
                sens = (swing * 12) / 16;
            end else begin
                sens    = int'(SENS_BAD);
                blk_bad = 1'b1;
            end
            if (mid_x < int'(XMID_MIN)) blk_bad = 1'b1;
            y_live = 1'b1;
            x_hi   = int'(SAMPLE_MIN);
            x_lo   = int'(SAMPLE_MAX);
            y_hi   = int'(SAMPLE_MIN);
            y_lo   = int'(SAMPLE_MAX);
        end

        // Until the first block has closed, the y channel reads as zero.
        ad = y_live ? sy : 0;
        if (ad > thr_hi) begin
            if (lvl != LV_HIGH) ext_old = ext_new;
            lvl = LV_HIGH;
            if (ad > ext_new) ext_new = ad;
        end else if (ad < thr_lo) begin
            if (lvl != LV_LOW) ext_old = ext_new;
            lvl = LV_LOW;
            if (ad < ext_new) ext_new = ad;
        end

        diff = ext_old - ext_new;
        if ((diff > sens || -diff > sens) && gap_cnt > cfg.min_interval) begin
            cand    = 1'b1;
            ext_old = ext_new;
        end

        if (cand && !blk_bad) res = window_step();
        else if (gap_cnt >= cfg.max_interval) restart_seek();

        o.step_total  = steps;
        o.find_result = res;
        return o;
    endfunction

    task automatic apb_write(t_reg_idx idx, logic [DATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_INTERVAL:     cfg.min_interval     = val[IVLCFG_W-1:0];
            REG_MAX_INTERVAL:     cfg.max_interval     = val[IVLCFG_W-1:0];
            REG_REGULARITY_STEPS: cfg.regularity_steps = val[STEPS_W-1:0];
            REG_INVALID_LIMIT:    cfg.invalid_limit    = val[STEPS_W-1:0];
            REG_MIN_SWING:        cfg.min_swing        = val[SWING_W-1:0];
            default: ;
        endcase
    endtask

    // Sample driver: a stalled transaction keeps its valid and payload.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                n_in++;
                expected_results.push_back(predict_sample(i_data));
            end
            if (!i_valid || !o_stall) begin
                if (sample_feed.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_valid <= 1'b1;
                    i_data  <= sample_feed.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                n_out++;
                if (expected_results.size() == 0) begin
                    n_fail++;
                    if (n_shown < SHOWN_MAX) begin
                        n_shown++;
                        $display("Result transaction %0d with nothing expected: step_total %0d find_result %0d",
                                 n_out, o_data.step_total, o_data.find_result);
                    end
                end else begin
                    want = expected_results.pop_front();
                    kind_seen[want.find_result]++;
                    if (o_data.step_total !== want.step_total ||
                        o_data.find_result !== want.find_result) begin
                        n_fail++;
                        if (n_shown < SHOWN_MAX) begin
                            n_shown++;
                            $display("Result transaction %0d: step_total expected %0d got %0d, find_result expected %0d got %0d",
                                     n_out, want.step_total, o_data.step_total,
                                     want.find_result, o_data.find_result);
                        end
                    end
                end
            end
            i_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin : stimulus
        t_in_item    s;
        t_cfg        c;
        int          ph, k, made, len, quota, h, amp, ctr, nz, yv, xv, left;
        int unsigned lo_i, hi_i;
        bit          up, bad_x, jitter, noisy;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            tx_idle_pct <= (ph < 2) ? 22 : (ph < 4) ? 57 : 0;
            rx_idle_pct <= (ph < 2) ? 57 : (ph < 4) ? 22 : 0;
            case (ph)
                0: c = '{RST_MIN_INTERVAL, RST_MAX_INTERVAL, RST_REGULARITY_STEPS,
                         RST_INVALID_LIMIT, RST_MIN_SWING};
                1: c = '{10'd0, 10'd1023, 8'd1, 8'd1, 12'd0};
                2: c = '{10'd1023, 10'd1, 8'd255, 8'd255, 12'd4095};
                default: begin
                    c.min_interval     = IVLCFG_W'($urandom_range(25, 3));
                    c.max_interval     = IVLCFG_W'($urandom_range(160, 30));
                    c.regularity_steps = STEPS_W'($urandom_range(6, 1));
                    c.invalid_limit    = STEPS_W'($urandom_range(6, 1));
                    c.min_swing        = SWING_W'($urandom_range(1200, 0));
                end
            endcase
            apb_write(REG_MIN_INTERVAL, DATA_W'(c.min_interval));
            apb_write(REG_MAX_INTERVAL, DATA_W'(c.max_interval));
            apb_write(REG_REGULARITY_STEPS, DATA_W'(c.regularity_steps));
            apb_write(REG_INVALID_LIMIT, DATA_W'(c.invalid_limit));
            apb_write(REG_MIN_SWING, DATA_W'(c.min_swing));

            if (ph == 0) begin
                for (k = 0; k < 12; k++) begin
                    s.accel_x = SAMPLE_W'(EDGE_X[k]);
                    s.accel_y = SAMPLE_W'(EDGE_Y[k]);
                    sample_feed.push_back(s);
                    n_queued++;
                end
            end

            // Mostly square-wave walking segments with random period, swing and
            // offset; some segments carry a bad x midpoint, a tiny swing or an
            // irregular period, and a few are plain noise.
            made  = 0;
            quota = PHASE_ITEMS[ph];
            while (made < quota) begin
                len = $urandom_range(120, 30);
                if (len > quota - made) len = quota - made;
                noisy = ($urandom_range(99) < 12);
                lo_i  = cfg.min_interval;
                hi_i  = cfg.max_interval;
                if (hi_i > 150) hi_i = 150;
                if (hi_i > lo_i + 1 && $urandom_range(9) < 7) h = $urandom_range(hi_i, lo_i + 1);
                else h = $urandom_range(130, 1);
                amp    = ($urandom_range(99) < 15) ? $urandom_range(30) : $urandom_range(2047, 60);
                ctr    = int'($urandom_range(600)) - 300;
                nz     = $urandom_range(40);
                bad_x  = ($urandom_range(9) == 0);
                jitter = ($urandom_range(9) < 2);
                up     = $urandom_range(1);
                left   = h;
                for (k = 0; k < len; k++) begin
                    if (noisy) begin
                        s = 24'($urandom);
                    end else begin
                        if (left == 0) begin
                            up   = !up;
                            left = jitter ? $urandom_range(2 * h, 1) : h;
                        end
                        left--;
                        yv = ctr + (up ? amp : -amp) + int'($urandom_range(2 * nz)) - nz;
                        if (yv > int'(SAMPLE_MAX)) yv = int'(SAMPLE_MAX);
                        if (yv < int'(SAMPLE_MIN)) yv = int'(SAMPLE_MIN);
                        xv = bad_x ? int'($urandom_range(1800)) - 900
                                   : 1000 + int'($urandom_range(1047));
                        s.accel_x = SAMPLE_W'(xv);
                        s.accel_y = SAMPLE_W'(yv);
                    end
                    sample_feed.push_back(s);
                    n_queued++;
                end
                made += len;
            end

            // Hold the receiver off long enough for the block to back up.
            if (ph == NUM_PHASES - 1) begin
                repeat (30) @(posedge i_clk);
                rx_hold <= 1'b1;
                repeat (64) @(posedge i_clk);
                rx_hold <= 1'b0;
            end

            while (n_in != n_queued || expected_results.size() != 0) @(posedge i_clk);
            repeat (4) @(posedge i_clk);
        end

        $display("Checked %0d result transactions from %0d samples under %0d register settings.",
                 n_out, n_in, NUM_PHASES);
        $display("Results: %0d idle, %0d not yet regular, %0d counted, %0d too close, %0d too far.",
                 kind_seen[FR_IDLE], kind_seen[FR_NOT_REGULAR], kind_seen[FR_OK],
                 kind_seen[FR_TOO_SMALL], kind_seen[FR_TOO_LARGE]);
        if (n_fail == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
